[rtl/core/easing_curve_evaluator_macros.svh]
// assertion macros for the easing curve evaluator
// bodies expect clk_i and rst_ni in the scope where they are used
`ifndef EASING_CURVE_EVALUATOR_MACROS_SVH
`define EASING_CURVE_EVALUATOR_MACROS_SVH

// same-cycle implication
`define ECE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("easing curve evaluator check failed");

// next-cycle implication
`define ECE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("easing curve evaluator check failed");

// implication after a fixed number of cycles
`define ECE_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("easing curve evaluator check failed");

`endif

[rtl/core/ece_pkg.sv]
// shared types and constants of the easing curve evaluator
// no dependencies
package ece_pkg;

  localparam int TIME_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;  // quotient below 2.0
  localparam int P_W       = FRAC_BITS + 2;  // progress up to 2.0
  localparam int PW_W      = FRAC_BITS + 5;  // powers up to 16.0
  localparam int U_W       = FRAC_BITS + 1;  // sine argument up to 1.0
  localparam int DIV_STAGES = Q_W;
  localparam int SIN_STAGES = 7;

  localparam logic [P_W-1:0] ONE  = P_W'(1) << FRAC_BITS;
  localparam logic [P_W-1:0] HALF = P_W'(1) << (FRAC_BITS - 1);
  localparam logic [P_W-1:0] TWO  = P_W'(2) << FRAC_BITS;

  localparam logic [3:0] OP_LINEAR   = 4'd0;
  localparam logic [3:0] OP_IN_FIRST = 4'd1;
  localparam logic [3:0] OP_IN_LAST  = 4'd4;
  localparam logic [3:0] OP_OUT_FIRST = 4'd5;
  localparam logic [3:0] OP_OUT_LAST = 4'd8;
  localparam logic [3:0] OP_IO_FIRST = 4'd9;
  localparam logic [3:0] OP_IO_LAST  = 4'd12;

  // taylor coefficients of sin(pi/2 x) in q30, highest order first
  localparam logic [30:0] SIN_TOP = 31'd3864;
  localparam logic [30:0] SIN_COEF [5] = '{31'd172272, 31'd5026995, 31'd85569306,
                                            31'd693598668, 31'd1686629713};
  localparam logic [61:0] HALF_Q30 = 62'd1 << 29;

  typedef enum logic [1:0] {
    CLS_LIN,
    CLS_IN,
    CLS_OUT,
    CLS_IO
  } ece_cls_e;

  typedef struct packed {
    logic [3:0] op;
    logic       one;   // result forced to 1.0
    logic       sat2;  // progress saturates at 2.0
  } ece_ctl_t;

  typedef struct packed {
    logic           one;
    ece_cls_e       cls;
    logic [1:0]     kind;  // 0 sine, 1 quad, 2 cubic, 3 quart
    logic           lo;    // progress below one half
    logic           neg;   // doubled progress went past 2.0
    logic           cneg;  // cosine quadrant is negative
    logic [P_W-1:0] p;
  } ece_eval_t;

endpackage

[rtl/core/ece_divider.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on ece_pkg
module ece_divider import ece_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  ece_ctl_t             ctl_i,
  input  logic [TIME_BITS-1:0] el_i,
  input  logic [TIME_BITS-1:0] du_i,
  output logic                 vld_o,
  output ece_ctl_t             ctl_o,
  output logic [Q_W-1:0]       q_o
);

  logic                 vld_q [1:DIV_STAGES];
  ece_ctl_t             ctl_q [1:DIV_STAGES];
  logic [TIME_BITS-1:0] du_q  [1:DIV_STAGES];
  logic [TIME_BITS-1:0] rem_q [1:DIV_STAGES];
  logic [Q_W-1:0]       q_q   [1:DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic                 vld_in;
    ece_ctl_t             ctl_in;
    logic [TIME_BITS-1:0] du_in;
    logic [TIME_BITS-1:0] rem_in;
    logic [Q_W-1:0]       q_in;
    logic                 nb;
    logic [TIME_BITS:0]   t;
    logic [TIME_BITS:0]   diff;
    logic                 ge;

    if (k == 0) begin : g_first
      // remainder after the bits above the quotient range is el >> 1
      assign vld_in = vld_i;
      assign ctl_in = ctl_i;
      assign du_in  = du_i;
      assign rem_in = {1'b0, el_i[TIME_BITS-1:1]};
      assign q_in   = '0;
      assign nb     = el_i[0];
    end else begin : g_rest
      assign vld_in = vld_q[k];
      assign ctl_in = ctl_q[k];
      assign du_in  = du_q[k];
      assign rem_in = rem_q[k];
      assign q_in   = q_q[k];
      assign nb     = 1'b0;
    end

    assign t    = {rem_in, nb};
    assign diff = t - {1'b0, du_in};
    assign ge   = (t >= {1'b0, du_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ctl_q[k+1] <= ctl_in;
      du_q[k+1]  <= du_in;
      rem_q[k+1] <= ge ? diff[TIME_BITS-1:0] : t[TIME_BITS-1:0];
      q_q[k+1]   <= {q_in[Q_W-2:0], ge};
    end
  end

  assign vld_o = vld_q[DIV_STAGES];
  assign ctl_o = ctl_q[DIV_STAGES];
  assign q_o   = q_q[DIV_STAGES];

endmodule

[rtl/core/ece_sine.sv]
// pipelined sin(pi/2 u) polynomial in q30, one multiply per stage
// depends on ece_pkg
module ece_sine import ece_pkg::*; (
  input  logic           clk_i,
  input  logic [U_W-1:0] u_i,
  output logic [31:0]    y_o
);

  logic [30:0] x_q   [1:6];
  logic [30:0] x2_q  [1:5];
  logic [30:0] acc_q [2:6];
  logic [31:0] y_q;
  logic [30:0] x_in;

  function automatic logic [31:0] rnd30(input logic [61:0] v);
    logic [61:0] t;
    t = v + HALF_Q30;
    return t[61:30];
  endfunction

  assign x_in = 31'(u_i) << (30 - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    x_q[1]   <= x_in;
    x2_q[1]  <= 31'(rnd30(62'(x_in) * 62'(x_in)));
    x_q[2]   <= x_q[1];
    x2_q[2]  <= x2_q[1];
    acc_q[2] <= SIN_COEF[0] - 31'(rnd30(62'(SIN_TOP) * 62'(x2_q[1])));
    for (int j = 3; j <= 6; j++) begin
      x_q[j]   <= x_q[j-1];
      acc_q[j] <= SIN_COEF[j-2] - 31'(rnd30(62'(acc_q[j-1]) * 62'(x2_q[j-1])));
    end
    for (int j = 3; j <= 5; j++) begin
      x2_q[j] <= x2_q[j-1];
    end
    y_q <= rnd30(62'(acc_q[6]) * 62'(x_q[6]));
  end

  assign y_o = y_q;

endmodule

[rtl/core/easing_curve_evaluator.sv]
// easing curve evaluator: start reaches done_o through the input, quotient,
// sine and output stages; one item accepted every cycle; busy is never raised
// the 17-stage quotient pipeline and the 7-stage sine polynomial set the depth
// rst_ni clears all valid bits at once, payload registers are not reset
// results come one cycle wide on done_o and the receiver cannot hold them off
`include "easing_curve_evaluator_macros.svh"
module easing_curve_evaluator import ece_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         operation_i,
  input  logic [15:0]        elapsed_i,
  input  logic [15:0]        duration_i,
  input  logic               go_back_i,
  output logic               done_o,
  output logic signed [19:0] eased_o
);

  localparam int LATENCY = 1 + DIV_STAGES + 1 + SIN_STAGES + 1;
  localparam int EV_LAST = SIN_STAGES;

  // input register
  logic                 vld0_q;
  logic [3:0]           op0_q;
  logic [TIME_BITS-1:0] el0_q;
  logic [TIME_BITS-1:0] du0_q;
  logic                 gb0_q;
  logic                 io0;
  ece_ctl_t             ctl0;

  logic                 div_vld;
  ece_ctl_t             div_ctl;
  logic [Q_W-1:0]       div_q;

  // curve setup
  logic [P_W-1:0] p;
  logic [P_W:0]   twop;
  logic [P_W:0]   m;
  logic [P_W-1:0] a;
  logic [U_W-1:0] u;
  logic [1:0]     quad;
  ece_eval_t      ev;

  logic            vld_q [0:EV_LAST];
  ece_eval_t       ev_q  [0:EV_LAST];
  logic [PW_W-1:0] pw_q  [0:EV_LAST];
  logic [P_W-1:0]  a_q   [0:2];
  logic [U_W-1:0]  u_q;
  logic [31:0]     sin_y;

  // result combine
  logic [32:0]        r_sum;
  logic [U_W-1:0]     s;
  logic signed [22:0] res;
  logic signed [22:0] s_x;
  logic signed [22:0] pw_x;
  logic signed [22:0] h_x;
  logic signed [22:0] v_x;
  logic signed [22:0] one_x;
  logic signed [19:0] sat;
  logic               done_q;
  logic signed [19:0] eased_q;

  function automatic logic [PW_W-1:0] mulf(input logic [PW_W-1:0] x,
                                            input logic [P_W-1:0] y);
    logic [PW_W+P_W-1:0] t;
    t = (PW_W+P_W)'(x) * (PW_W+P_W)'(y) + (PW_W+P_W)'(ONE >> 1);
    return t[FRAC_BITS +: PW_W];
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op0_q <= operation_i;
      el0_q <= elapsed_i[TIME_BITS-1:0];
      du0_q <= duration_i[TIME_BITS-1:0];
      gb0_q <= go_back_i;
    end
  end

  assign io0       = (op0_q >= OP_IO_FIRST) && (op0_q <= OP_IO_LAST);
  assign ctl0.op   = op0_q;
  assign ctl0.one  = (du0_q == '0) || ((el0_q > du0_q) && !(io0 && gb0_q));
  assign ctl0.sat2 = ({1'b0, el0_q} >= {du0_q, 1'b0});

  ece_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld0_q),
    .ctl_i  (ctl0),
    .el_i   (el0_q),
    .du_i   (du0_q),
    .vld_o  (div_vld),
    .ctl_o  (div_ctl),
    .q_o    (div_q)
  );

  always_comb begin
    p    = div_ctl.sat2 ? TWO : P_W'(div_q);
    twop = {p, 1'b0};
    ev.one  = div_ctl.one;
    ev.p    = p;
    ev.lo   = (p < HALF);
    ev.neg  = (twop > {1'b0, TWO});
    ev.kind = 2'(div_ctl.op - 4'd1);
    m    = ev.neg ? (twop - {1'b0, TWO}) : ({1'b0, TWO} - twop);
    quad = twop[FRAC_BITS +: 2];
    ev.cneg = quad[0] ^ quad[1];
    case (div_ctl.op) inside
      [OP_IN_FIRST:OP_IN_LAST]:   ev.cls = CLS_IN;
      [OP_OUT_FIRST:OP_OUT_LAST]: ev.cls = CLS_OUT;
      [OP_IO_FIRST:OP_IO_LAST]:   ev.cls = CLS_IO;
      default: begin
        ev.cls  = CLS_LIN;
        ev.kind = 2'(OP_LINEAR);
      end
    endcase
    case (ev.cls)
      CLS_IN: begin
        a = p;
        u = U_W'(ONE - p);
      end
      CLS_OUT: begin
        a = ONE - p;
        u = p[U_W-1:0];
      end
      CLS_IO: begin
        a = ev.lo ? p : m[P_W-1:0];
        // cos(pi p) from the sine of the quadrant remainder
        u = quad[0] ? U_W'(twop[FRAC_BITS-1:0])
                    : U_W'(ONE - P_W'(twop[FRAC_BITS-1:0]));
      end
      default: begin
        a = p;
        u = p[U_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= EV_LAST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= div_vld;
      for (int k = 0; k < EV_LAST; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  // powers take up to three multiply stages, the rest only delays to the sine
  always_ff @(posedge clk_i) begin
    ev_q[0] <= ev;
    a_q[0]  <= a;
    pw_q[0] <= PW_W'(a);
    u_q     <= u;
    for (int k = 0; k < 2; k++) begin
      a_q[k+1] <= a_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      ev_q[k+1] <= ev_q[k];
      pw_q[k+1] <= (ev_q[k].kind > 2'(k)) ? mulf(pw_q[k], a_q[k]) : pw_q[k];
    end
    for (int k = 3; k < EV_LAST; k++) begin
      ev_q[k+1] <= ev_q[k];
      pw_q[k+1] <= pw_q[k];
    end
  end

  ece_sine u_sin (
    .clk_i (clk_i),
    .u_i   (u_q),
    .y_o   (sin_y)
  );

  always_comb begin
    r_sum = {1'b0, sin_y} + (33'd1 << (29 - FRAC_BITS));
    s     = (r_sum[32:30-FRAC_BITS] > 19'(ONE)) ? U_W'(ONE)
                                                 : r_sum[30-FRAC_BITS +: U_W];
    s_x   = 23'(s);
    pw_x  = 23'(pw_q[EV_LAST]);
    one_x = 23'(ONE);
    h_x   = (pw_x + 23'sd1) >>> 1;
    v_x   = one_x - (ev_q[EV_LAST].cneg ? -s_x : s_x);
    case (ev_q[EV_LAST].cls)
      CLS_IN:  res = (ev_q[EV_LAST].kind == 2'd0) ? (one_x - s_x) : pw_x;
      CLS_OUT: res = (ev_q[EV_LAST].kind == 2'd0) ? s_x : (one_x - pw_x);
      CLS_IO: begin
        if (ev_q[EV_LAST].kind == 2'd0) begin
          res = (v_x + 23'sd1) >>> 1;
        end else if (ev_q[EV_LAST].lo) begin
          res = pw_x <<< ev_q[EV_LAST].kind;
        end else if (ev_q[EV_LAST].neg && !ev_q[EV_LAST].kind[0]) begin
          // odd power of a negative base
          res = one_x + h_x;
        end else begin
          res = one_x - h_x;
        end
      end
      default: res = 23'(ev_q[EV_LAST].p);
    endcase
    if (ev_q[EV_LAST].one) begin
      res = one_x;
    end
    if (res > 23'sd524287) begin
      sat = 20'sd524287;
    end else if (res < -23'sd524288) begin
      sat = -20'sd524288;
    end else begin
      sat = res[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[EV_LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    eased_q <= sat;
  end

  assign done_o  = done_q;
  assign eased_o = eased_q;

  `ECE_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done_o)
  `ECE_ASSERT_IMPLY(a_no_spurious, done_o, $past(start && !busy, LATENCY))
  `ECE_ASSERT_NEXT(a_full_scale, vld_q[EV_LAST] && ev_q[EV_LAST].one, eased_o == 20'sd65536)

endmodule
